// ===== hdl/bpfa_pkg.sv =====
// Shared types and constants for the bitmap page frame allocator.
// No dependencies; every other file of the block except bpfa_ram imports this package.
package bpfa_pkg;

    localparam int MAX_FRAMES  = 65536;
    localparam int WORD_BITS   = 64;
    localparam int BIT_W       = $clog2(WORD_BITS);
    localparam int WORD_COUNT  = MAX_FRAMES / WORD_BITS;
    localparam int WORD_AW     = $clog2(WORD_COUNT);
    localparam int SCAN_W      = WORD_AW + 1;
    localparam int BYTE_CAP    = WORD_COUNT * 8;

    localparam int CMD_W       = 2;
    localparam int FRAME_W     = 16;
    localparam int STATUS_W    = 2;
    localparam int BYTES_W     = 14;
    localparam logic [BYTES_W-1:0] BYTES_RESET = 14'd8192;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC     = 2'd0,
        CMD_FREE      = 2'd1,
        CMD_MARK_USED = 2'd2,
        CMD_MARK_FREE = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK    = 2'd0,
        STS_OOM   = 2'd1,
        STS_RANGE = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_TAIL_RD,
        S_TAIL_CHK,
        S_HIT,
        S_MOD_RD,
        S_MOD_WR,
        S_DONE
    } t_state;

    // Controller to datapath commands.
    typedef struct packed {
        logic clr_wr;
        logic load_item;
        logic alloc_init;
        logic scan_step;
        logic hit_capture;
        logic tail_rd;
        logic tail_capture;
        logic hit_write;
        logic item_rd;
        logic item_wr;
        logic set_oom;
        logic set_range;
        logic out_load;
    } t_dp_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic clr_done;
        logic is_alloc;
        logic in_range;
        logic words_zero;
        logic tail_avail;
        logic rd_hit;
        logic rd_end;
        logic tail_hit;
    } t_dp_status;

endpackage

// ===== hdl/bpfa_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Depends on nothing.
module bpfa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/bpfa_datapath.sv =====
// Datapath of the frame allocator: bitmap RAM, hint, scan counters, result registers.
// Depends on bpfa_pkg and bpfa_ram; driven by bpfa_ctrl.
module bpfa_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bpfa_pkg::t_dp_cmd             i_cmd,
    output bpfa_pkg::t_dp_status          o_status_flags,
    input  logic                          i_cfg_we,
    input  logic [bpfa_pkg::BYTES_W-1:0]  i_cfg_bytes,
    input  logic [bpfa_pkg::CMD_W-1:0]    i_command,
    input  logic [bpfa_pkg::FRAME_W-1:0]  i_frame,
    output logic [bpfa_pkg::FRAME_W-1:0]  o_alloc_frame,
    output logic [bpfa_pkg::STATUS_W-1:0] o_status
);
    import bpfa_pkg::*;

    localparam logic [WORD_BITS-1:0] ONES = {WORD_BITS{1'b1}};

    // Lowest clear bit by binary search: six halving steps.
    function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_BITS-1:0] w);
        logic [WORD_BITS-1:0] v;
        logic [WORD_BITS-1:0] m;
        logic [BIT_W-1:0]     b;
        v = w;
        b = '0;
        for (int k = BIT_W - 1; k >= 0; k--) begin
            m = (WORD_BITS'(1) << (1 << k)) - WORD_BITS'(1);
            if ((v & m) == m) begin
                v = v >> (1 << k);
                b = b | BIT_W'(1 << k);
            end
        end
        return b;
    endfunction

    logic [BYTES_W-1:0]  r_bytes;
    logic [WORD_AW-1:0]  r_hint;
    logic [WORD_AW-1:0]  r_clr_idx;
    t_cmd                r_cmd;
    logic [FRAME_W-1:0]  r_frame;
    logic [WORD_AW-1:0]  r_idx;
    logic [SCAN_W-1:0]   r_left;
    logic                r_rd_vld;
    logic                r_rd_last;
    logic [WORD_AW-1:0]  r_rd_idx;
    logic [WORD_BITS-1:0] r_word;
    logic [WORD_AW-1:0]  r_word_idx;
    logic                r_tail;
    logic [FRAME_W-1:0]  r_res_frame;
    t_status             r_res_status;
    logic [FRAME_W-1:0]  r_out_frame;
    t_status             r_out_status;

    logic [BYTES_W-1:0]   eff_bytes;
    logic [SCAN_W-1:0]    words;
    logic [2:0]           rem;
    logic [WORD_AW-1:0]   tail_idx;
    logic [WORD_AW-1:0]   start_idx;
    logic [WORD_AW-1:0]   next_idx;
    logic [WORD_AW-1:0]   item_idx;
    logic [WORD_BITS-1:0] item_bit;
    logic [WORD_BITS-1:0] tail_fill;
    logic [WORD_BITS-1:0] enc_word;
    logic [BIT_W-1:0]     hit_bit;
    logic [WORD_BITS-1:0] rd_data;
    logic                 wr_en;
    logic [WORD_AW-1:0]   wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic                 rd_en;
    logic [WORD_AW-1:0]   rd_addr;

    always_comb begin
        if (32'(r_bytes) > BYTE_CAP) begin
            eff_bytes = BYTES_W'(BYTE_CAP);
        end else begin
            eff_bytes = r_bytes;
        end
        words     = SCAN_W'(eff_bytes >> 3);
        rem       = eff_bytes[2:0];
        tail_idx  = WORD_AW'(words);
        start_idx = (SCAN_W'(r_hint) < words) ? r_hint : '0;
        next_idx  = ((SCAN_W'(r_idx) + SCAN_W'(1)) == words) ? '0 : r_idx + WORD_AW'(1);
        item_idx  = WORD_AW'(r_frame >> BIT_W);
        item_bit  = WORD_BITS'(1) << r_frame[BIT_W-1:0];
        tail_fill = ONES << {rem, 3'b000};
        enc_word  = r_tail ? (r_word | tail_fill) : r_word;
        hit_bit   = lowest_zero(enc_word);
    end

    // Port muxing for the bitmap RAM.
    always_comb begin
        rd_en   = i_cmd.scan_step | i_cmd.tail_rd | i_cmd.item_rd;
        rd_addr = item_idx;
        if (i_cmd.scan_step) begin
            rd_addr = r_idx;
        end else if (i_cmd.tail_rd) begin
            rd_addr = tail_idx;
        end
        wr_en   = i_cmd.clr_wr | i_cmd.hit_write | i_cmd.item_wr;
        wr_addr = item_idx;
        wr_data = (r_cmd == CMD_MARK_USED) ? (rd_data | item_bit) : (rd_data & ~item_bit);
        if (i_cmd.clr_wr) begin
            wr_addr = r_clr_idx;
            wr_data = ONES;
        end else if (i_cmd.hit_write) begin
            wr_addr = r_word_idx;
            wr_data = r_word | (WORD_BITS'(1) << hit_bit);
        end
    end

    bpfa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORD_COUNT)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes   <= BYTES_RESET;
            r_hint    <= '0;
            r_clr_idx <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_bytes <= i_cfg_bytes;
            end
            if (i_cmd.clr_wr) begin
                r_clr_idx <= r_clr_idx + WORD_AW'(1);
            end
            r_rd_vld <= i_cmd.scan_step && (r_left != '0);
            if (i_cmd.hit_write && !r_tail) begin
                r_hint <= r_word_idx;
            end
            if (i_cmd.item_wr && (r_cmd == CMD_FREE) && (item_idx < r_hint)) begin
                r_hint <= item_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_cmd        <= t_cmd'(i_command);
            r_frame      <= i_frame;
            r_res_frame  <= '0;
            r_res_status <= STS_OK;
        end
        if (i_cmd.alloc_init) begin
            r_idx  <= start_idx;
            r_left <= words;
        end
        if (i_cmd.scan_step) begin
            r_rd_idx  <= r_idx;
            r_rd_last <= (r_left == SCAN_W'(1));
            if (r_left != '0) begin
                r_idx  <= next_idx;
                r_left <= r_left - SCAN_W'(1);
            end
        end
        if (i_cmd.hit_capture) begin
            r_word     <= rd_data;
            r_word_idx <= r_rd_idx;
            r_tail     <= 1'b0;
        end
        if (i_cmd.tail_capture) begin
            r_word     <= rd_data;
            r_word_idx <= tail_idx;
            r_tail     <= 1'b1;
        end
        if (i_cmd.hit_write) begin
            r_res_frame <= FRAME_W'({r_word_idx, hit_bit});
        end
        if (i_cmd.set_oom) begin
            r_res_status <= STS_OOM;
        end
        if (i_cmd.set_range) begin
            r_res_status <= STS_RANGE;
        end
        if (i_cmd.out_load) begin
            r_out_frame  <= r_res_frame;
            r_out_status <= r_res_status;
        end
    end

    always_comb begin
        o_status_flags.clr_done   = (r_clr_idx == WORD_AW'(WORD_COUNT - 1));
        o_status_flags.is_alloc   = (r_cmd == CMD_ALLOC);
        o_status_flags.in_range   = ({1'b0, r_frame} < {eff_bytes, 3'b000});
        o_status_flags.words_zero = (words == '0);
        o_status_flags.tail_avail = (rem != 3'd0);
        o_status_flags.rd_hit     = r_rd_vld && (rd_data != ONES);
        o_status_flags.rd_end     = r_rd_vld && r_rd_last;
        o_status_flags.tail_hit   = ((rd_data | tail_fill) != ONES);
    end

    assign o_alloc_frame = r_out_frame;
    assign o_status      = r_out_status;

endmodule

// ===== hdl/bpfa_ctrl.sv =====
// Control state machine of the frame allocator: sequences clear, scan and update steps.
// Depends on bpfa_pkg; drives bpfa_datapath through command and status structs.
module bpfa_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    input  bpfa_pkg::t_dp_status i_flags,
    output bpfa_pkg::t_dp_cmd    o_cmd
);
    import bpfa_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_flags.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_flags.is_alloc) begin
                    o_cmd.alloc_init = 1'b1;
                    if (!i_flags.words_zero) begin
                        n_state = S_SCAN;
                    end else if (i_flags.tail_avail) begin
                        n_state = S_TAIL_RD;
                    end else begin
                        o_cmd.set_oom = 1'b1;
                        n_state       = S_DONE;
                    end
                end else if (i_flags.in_range) begin
                    n_state = S_MOD_RD;
                end else begin
                    o_cmd.set_range = 1'b1;
                    n_state         = S_DONE;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_flags.rd_hit) begin
                    o_cmd.hit_capture = 1'b1;
                    n_state           = S_HIT;
                end else if (i_flags.rd_end) begin
                    if (i_flags.tail_avail) begin
                        n_state = S_TAIL_RD;
                    end else begin
                        o_cmd.set_oom = 1'b1;
                        n_state       = S_DONE;
                    end
                end
            end
            S_TAIL_RD: begin
                o_cmd.tail_rd = 1'b1;
                n_state       = S_TAIL_CHK;
            end
            S_TAIL_CHK: begin
                if (i_flags.tail_hit) begin
                    o_cmd.tail_capture = 1'b1;
                    n_state            = S_HIT;
                end else begin
                    o_cmd.set_oom = 1'b1;
                    n_state       = S_DONE;
                end
            end
            S_HIT: begin
                o_cmd.hit_write = 1'b1;
                n_state         = S_DONE;
            end
            S_MOD_RD: begin
                o_cmd.item_rd = 1'b1;
                n_state       = S_MOD_WR;
            end
            S_MOD_WR: begin
                o_cmd.item_wr = 1'b1;
                n_state       = S_DONE;
            end
            S_DONE: begin
                // Hold the result until the output register is free.
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== hdl/bitmap_page_frame_allocator_top.sv =====
// Top level of the next-fit bitmap page frame allocator; depends on bpfa_pkg,
// bpfa_ctrl, bpfa_datapath and bpfa_ram. One command at a time.
// Mark/free reads and rewrites one bitmap word; alloc scans the words from the hint,
// one word per cycle (single RAM read port), then checks the trailing bytes if none hits.
// A new command is taken only after the previous result has entered the output register.
// Reset: synchronous, active low; a clearing pass then sets every frame used.
module bitmap_page_frame_allocator_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [bpfa_pkg::CMD_W-1:0]    i_command,
    input  logic [bpfa_pkg::FRAME_W-1:0]  i_frame,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [bpfa_pkg::FRAME_W-1:0]  o_alloc_frame,
    output logic [bpfa_pkg::STATUS_W-1:0] o_status,
    // configuration: bitmap length in bytes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bpfa_pkg::BYTES_W-1:0]  i_cfg_bitmap_bytes
);
    import bpfa_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_flags;

    // The length register takes a transfer on every cycle, clearing pass included.
    assign o_cfg_ready = 1'b1;

    // Controller: accepts a command only from idle and holds the result
    // in the output register until the consumer releases its stall.
    bpfa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_flags     (dp_flags),
        .o_cmd       (dp_cmd)
    );

    // Datapath: bitmap store, next-fit hint, word scan and result registers.
    bpfa_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_status_flags (dp_flags),
        .i_cfg_we       (i_cfg_valid & o_cfg_ready),
        .i_cfg_bytes    (i_cfg_bitmap_bytes),
        .i_command      (i_command),
        .i_frame        (i_frame),
        .o_alloc_frame  (o_alloc_frame),
        .o_status       (o_status)
    );

endmodule

// ===== tb/bpfa_checker.sv =====
// Result checker for the bitmap page frame allocator testbench.
// Depends on bpfa_pkg; watches the command, result and length-write transfers.
module bpfa_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic [bpfa_pkg::CMD_W-1:0]    i_command,
    input  logic [bpfa_pkg::FRAME_W-1:0]  i_frame,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [bpfa_pkg::FRAME_W-1:0]  i_alloc_frame,
    input  logic [bpfa_pkg::STATUS_W-1:0] i_status,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [bpfa_pkg::BYTES_W-1:0]  i_cfg_bitmap_bytes,
    output logic [31:0]                   o_fail_count,
    output logic [31:0]                   o_pending,
    output logic [31:0]                   o_results
);
    import bpfa_pkg::*;

    typedef struct {
        logic [FRAME_W-1:0] frame;
        t_status            status;
    } t_reply;

    logic [WORD_BITS-1:0] frame_map [WORD_COUNT];
    int                   scan_hint;
    logic [BYTES_W-1:0]   len_bytes;
    t_reply               reply_q [$];
    int                   mismatches;
    int                   results_seen;

    function automatic int first_zero(input logic [WORD_BITS-1:0] v);
        for (int k = 0; k < WORD_BITS; k++)
            if (!v[k]) return k;
        return 0;
    endfunction

    // Next-fit allocation and bit updates on the shadow bitmap.
    task automatic predict_command(input t_cmd cmd, input logic [FRAME_W-1:0] frame,
                                   output t_reply r);
        int                   eff;
        int                   words;
        int                   rem;
        int                   lim;
        int                   hit_w;
        int                   b;
        bit                   found;
        logic [WORD_BITS-1:0] tail_mask;
        logic [WORD_BITS-1:0] tail_word;
        r.frame  = '0;
        r.status = STS_OK;
        eff = (int'(len_bytes) > BYTE_CAP) ? BYTE_CAP : int'(len_bytes);
        if (cmd == CMD_ALLOC) begin
            words = eff >> 3;
            rem   = eff & 7;
            lim   = (scan_hint < words) ? scan_hint : words;
            found = 1'b0;
            hit_w = 0;
            for (int i = scan_hint; i < words; i++)
                if (!found && frame_map[i] != '1) begin
                    found = 1'b1;
                    hit_w = i;
                end
            for (int i = 0; i < lim; i++)
                if (!found && frame_map[i] != '1) begin
                    found = 1'b1;
                    hit_w = i;
                end
            if (found) begin
                b = first_zero(frame_map[hit_w]);
                frame_map[hit_w][b] = 1'b1;
                scan_hint = hit_w;
                r.frame = FRAME_W'(hit_w * WORD_BITS + b);
            end else begin
                r.status = STS_OOM;
                // whole words are full: try the trailing bytes, hint stays put
                if (rem != 0 && words < WORD_COUNT) begin
                    tail_mask = (64'd1 << (rem * 8)) - 64'd1;
                    tail_word = frame_map[words] | ~tail_mask;
                    if (tail_word != '1) begin
                        b = first_zero(tail_word);
                        frame_map[words][b] = 1'b1;
                        r.frame  = FRAME_W'(words * WORD_BITS + b);
                        r.status = STS_OK;
                    end
                end
            end
        end else if (int'(frame) >= eff * 8) begin
            r.status = STS_RANGE;
        end else begin
            hit_w = int'(frame >> BIT_W);
            frame_map[hit_w][frame[BIT_W-1:0]] = (cmd == CMD_MARK_USED);
            if (cmd == CMD_FREE && hit_w < scan_hint)
                scan_hint = hit_w;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_reply want;
        if (!i_rst_n) begin
            for (int i = 0; i < WORD_COUNT; i++)
                frame_map[i] = '1;
            scan_hint    = 0;
            len_bytes    = BYTES_RESET;
            reply_q.delete();
            mismatches   = 0;
            results_seen = 0;
            o_fail_count <= '0;
            o_pending    <= '0;
            o_results    <= '0;
        end else begin
            // retire the oldest expectation first; a same-edge command is younger
            if (i_out_valid && !i_out_stall) begin
                results_seen++;
                if (reply_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with nothing expected: frame %0d st %0d",
                                 $realtime, i_alloc_frame, i_status);
                end else begin
                    want = reply_q.pop_front();
                    if (i_alloc_frame !== want.frame || i_status !== want.status) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: mismatch: frame exp %0d got %0d, st exp %0d got %0d",
                                     $realtime, want.frame, i_alloc_frame,
                                     want.status, i_status);
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                len_bytes = i_cfg_bitmap_bytes;
            if (i_in_valid && !i_in_stall) begin
                predict_command(t_cmd'(i_command), i_frame, want);
                reply_q.push_back(want);
            end
            o_fail_count <= mismatches;
            o_pending    <= reply_q.size();
            o_results    <= results_seen;
        end
    end

endmodule

// ===== tb/tb_bitmap_page_frame_allocator_top.sv =====
// Testbench top for the bitmap page frame allocator: clock, reset, stimulus, verdict.
// Depends on bpfa_pkg, bpfa_checker and the RTL top bitmap_page_frame_allocator_top.
module tb_bitmap_page_frame_allocator_top;
    import bpfa_pkg::*;

    localparam int CHURN_ITEMS  = 900;
    localparam int DRAIN_CYCLES = 200000;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [CMD_W-1:0]    i_command;
    logic [FRAME_W-1:0]  i_frame;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [FRAME_W-1:0]  o_alloc_frame;
    logic [STATUS_W-1:0] o_status;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [BYTES_W-1:0]  i_cfg_bitmap_bytes;

    logic [31:0]         fail_count;
    logic [31:0]         pending;
    logic [31:0]         results;

    // sender burst bookkeeping: items left before the next gap
    int                  burst_left;

    bitmap_page_frame_allocator_top u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_command          (i_command),
        .i_frame            (i_frame),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_alloc_frame      (o_alloc_frame),
        .o_status           (o_status),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_bitmap_bytes (i_cfg_bitmap_bytes)
    );

    bpfa_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .i_in_stall         (o_in_stall),
        .i_command          (i_command),
        .i_frame            (i_frame),
        .i_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .i_alloc_frame      (o_alloc_frame),
        .i_status           (o_status),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_ready        (o_cfg_ready),
        .i_cfg_bitmap_bytes (i_cfg_bitmap_bytes),
        .o_fail_count       (fail_count),
        .o_pending          (pending),
        .o_results          (results)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Drive one command transfer. Insert a random gap whenever a burst runs out,
    // then hold the payload until the block takes it.
    task automatic issue(input t_cmd cmd, input logic [FRAME_W-1:0] frame);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap) begin
                @(negedge i_clk);
                i_in_valid = 1'b0;
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_command  = cmd;
        i_frame    = frame;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Write the bitmap length only once the block has drained: drop valid,
    // wait out every expected result, leave a short settle time, then transfer.
    task automatic set_length(input logic [BYTES_W-1:0] nbytes);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        i_cfg_valid        = 1'b1;
        i_cfg_bitmap_bytes = nbytes;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // One random command, mostly aimed inside the live range, with some
    // full-width noise and hits on the range boundary.
    task automatic churn_item(input int nframes);
        int                 pick;
        t_cmd               cmd;
        logic [FRAME_W-1:0] fr;
        pick = $urandom_range(0, 99);
        if (pick < 38)      cmd = CMD_ALLOC;
        else if (pick < 62) cmd = CMD_MARK_FREE;
        else if (pick < 84) cmd = CMD_FREE;
        else                cmd = CMD_MARK_USED;
        pick = $urandom_range(0, 99);
        if (nframes == 0 || pick < 12)
            fr = FRAME_W'($urandom);
        else if (pick < 17)
            fr = FRAME_W'(nframes - 1 + $urandom_range(0, 1));
        else
            fr = FRAME_W'($urandom_range(0, nframes - 1));
        issue(cmd, fr);
    endtask

    initial begin : stimulus
        int                 churned;
        int                 pick;
        int                 nframes;
        int                 span;
        int                 base;
        int                 guard;
        logic [BYTES_W-1:0] nbytes;

        // known values on every input from time zero
        i_rst_n            = 1'b0;
        i_in_valid         = 1'b0;
        i_command          = CMD_ALLOC;
        i_frame            = '0;
        i_cfg_valid        = 1'b0;
        i_cfg_bitmap_bytes = '0;
        burst_left         = 0;
        churned            = 0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part at the reset length (full 8192 bytes).
        // Everything is used after reset, so the first alloc scans all words and fails.
        issue(CMD_ALLOC, 16'h0000);
        issue(CMD_MARK_FREE, 16'hFFFF);          // top frame of the map
        issue(CMD_MARK_FREE, 16'd3200);          // word 50
        issue(CMD_ALLOC, 16'hFFFF);              // grant from word 50, hint moves there
        issue(CMD_ALLOC, 16'h0000);              // grant the top frame, hint to last word
        issue(CMD_FREE, 16'h0000);               // free below the hint pulls it to zero
        issue(CMD_ALLOC, 16'h5555);              // grant frame zero again
        issue(CMD_MARK_USED, 16'd3200);
        issue(CMD_MARK_FREE, 16'd3201);
        issue(CMD_ALLOC, 16'hAAAA);              // hint back to word 50
        issue(CMD_MARK_FREE, 16'd70);            // marking leaves the hint alone

        // Shrink to two words: the hint is now stale, so the wrap pass covers all.
        set_length(14'd16);
        issue(CMD_ALLOC, 16'h0000);
        issue(CMD_ALLOC, 16'h0000);              // nothing left: out of memory
        issue(CMD_FREE, 16'd200);                // beyond the map
        issue(CMD_MARK_USED, 16'd128);           // first frame past the end
        issue(CMD_MARK_FREE, 16'd127);           // last frame inside
        issue(CMD_FREE, 16'd3);

        // One whole word plus five trailing bytes.
        set_length(14'd13);
        issue(CMD_MARK_FREE, 16'd100);           // inside the trailing bytes
        issue(CMD_MARK_FREE, 16'd104);           // just past them
        issue(CMD_ALLOC, 16'h0000);              // whole word first
        issue(CMD_ALLOC, 16'h0000);              // then the trailing bytes
        issue(CMD_ALLOC, 16'h0000);

        // Zero length: alloc runs dry, every other command is out of range.
        set_length(14'd0);
        issue(CMD_ALLOC, 16'h0000);
        issue(CMD_MARK_FREE, 16'h0000);

        // Largest register value behaves as the full map.
        set_length(14'd16383);
        issue(CMD_MARK_FREE, 16'hAAAA);
        issue(CMD_ALLOC, 16'hFFFF);

        // Random phases: a new length each phase, opened by a run of freed frames
        // so that allocs find space, then mixed traffic. Large maps get few items
        // since a miss walks every word.
        while (churned < CHURN_ITEMS) begin
            pick = $urandom_range(0, 15);
            case (pick)
                0:       nbytes = 14'd0;
                1:       nbytes = 14'd8192;
                2:       nbytes = BYTES_W'($urandom_range(8193, 16383));
                3:       nbytes = 14'd16383;
                4:       nbytes = BYTES_W'($urandom_range(97, 8191));
                default: nbytes = BYTES_W'($urandom_range(1, 96));
            endcase
            set_length(nbytes);
            nframes = ((int'(nbytes) > BYTE_CAP) ? BYTE_CAP : int'(nbytes)) * 8;
            if (nframes == 0)
                span = 10;
            else if (nframes > 768)
                span = $urandom_range(12, 20);
            else
                span = $urandom_range(30, 60);
            if (nframes > 0) begin
                base = $urandom_range(0, nframes - 1);
                repeat ($urandom_range(2, 8)) begin
                    issue(CMD_MARK_FREE, FRAME_W'(base));
                    base = (base + 1) % nframes;
                    churned++;
                end
            end
            repeat (span) begin
                churn_item(nframes);
                churned++;
            end
        end

        // Drain: drop valid, wait for the last result, then let the block settle.
        @(negedge i_clk);
        i_in_valid = 1'b0;
        guard = 0;
        while (pending != 0 && guard < DRAIN_CYCLES) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (40) @(negedge i_clk);

        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Receiver: stall in segments of random style, and twice hold off for a
    // long stretch so the block backs up and stalls the command side.
    initial begin : result_side
        int seg_left;
        int seg_mode;
        int hold_left;
        int holds_done;
        i_out_stall = 1'b0;
        seg_left    = 0;
        seg_mode    = 0;
        hold_left   = 0;
        holds_done  = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left == 0 && holds_done < 2 &&
                results >= ((holds_done == 0) ? 150 : 600)) begin
                hold_left = 400;
                holds_done++;
            end
            if (seg_left == 0) begin
                seg_mode = $urandom_range(0, 3);
                seg_left = $urandom_range(10, 120);
            end
            seg_left--;
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall = 1'b1;
            end else begin
                case (seg_mode)
                    0:       i_out_stall = 1'b0;
                    1:       i_out_stall = ($urandom_range(0, 2) == 0);
                    2:       i_out_stall = ($urandom_range(0, 3) != 0);
                    default: i_out_stall = ((seg_left % 4) < 2);
                endcase
            end
        end
    end

    // Hard stop well past the slowest correct run.
    initial begin : watchdog
        #60000000;
        $display("status: fail");
        $finish;
    end

endmodule
